// ===== rtl/pbd_pkg.sv =====
// Shared types, codes and default sizes for the deduplicating packet FIFO.
`timescale 1ns / 1ps
`default_nettype none
package pbd_pkg;

    localparam int DEPTH_DEF     = 64;
    localparam int ID_BITS_DEF   = 16;
    localparam int TIME_BITS_DEF = 32;
    localparam int FUNC_W        = 2;
    localparam int LIMIT_W       = 7;
    localparam int COUNT_W       = 7;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_FWD   = 2'd1,
        FUNC_COUNT = 2'd2,
        FUNC_NOP   = 2'd3
    } t_func;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_RDHEAD = 5'b00100,
        ST_WRITE  = 5'b01000,
        ST_FINISH = 5'b10000
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // capture the incoming word and clear scan state
        logic scan;     // step the scan over stored entries
        logic rd_head;  // read the oldest entry
        logic write;    // append the captured packet, evicting if needed
        logic finish;   // present the result and retire a forward
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_func func;
        logic  scan_end;
        logic  hit;
    } t_status;

endpackage
`default_nettype wire

// ===== rtl/pbd_ctrl.sv =====
// Sequencing state machine for the deduplicating packet FIFO.
`timescale 1ns / 1ps
`default_nettype none
module pbd_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [pbd_pkg::FUNC_W-1:0]  i_func,
    input  wire pbd_pkg::t_status            i_status,
    output pbd_pkg::t_cmd                    o_cmd,
    output logic                             o_busy
);
    import pbd_pkg::*;

    t_state r_state;
    t_state n_state;
    t_func  in_func;

    assign in_func = t_func'(i_func);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    case (in_func)
                        FUNC_ADD, FUNC_COUNT: n_state = ST_SCAN;
                        FUNC_FWD:             n_state = ST_RDHEAD;
                        default:              n_state = ST_FINISH;
                    endcase
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.scan_end) begin
                    if (i_status.func == FUNC_ADD && !i_status.hit) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_RDHEAD: begin
                o_cmd.rd_head = 1'b1;
                n_state       = ST_FINISH;
            end
            ST_WRITE: begin
                o_cmd.write = 1'b1;
                n_state     = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule
`default_nettype wire

// ===== rtl/pbd_dpath.sv =====
// Ring storage, pointers, scan compare and result registers of the packet FIFO.
`timescale 1ns / 1ps
`default_nettype none
module pbd_dpath #(
    parameter int DEPTH     = pbd_pkg::DEPTH_DEF,
    parameter int ID_BITS   = pbd_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = pbd_pkg::TIME_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pbd_pkg::t_cmd                 i_cmd,
    output pbd_pkg::t_status                   o_status,
    input  wire logic                          i_cfg_we,
    input  wire logic [pbd_pkg::LIMIT_W-1:0]   i_cfg_data,
    input  wire logic [pbd_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [ID_BITS-1:0]            i_source,
    input  wire logic [ID_BITS-1:0]            i_destination,
    input  wire logic [TIME_BITS-1:0]          i_timestamp,
    input  wire logic [TIME_BITS-1:0]          i_start_time,
    input  wire logic [TIME_BITS-1:0]          i_end_time,
    output logic                               o_valid,
    output logic                               o_accepted,
    output logic                               o_found,
    output logic [ID_BITS-1:0]                 o_out_source,
    output logic [ID_BITS-1:0]                 o_out_destination,
    output logic [TIME_BITS-1:0]               o_out_timestamp,
    output logic [pbd_pkg::COUNT_W-1:0]        o_match_count
);
    import pbd_pkg::*;

    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = $clog2(DEPTH + 1);
    localparam int CW    = (OW > LIMIT_W) ? OW : LIMIT_W;
    localparam int ENT_W = 2 * ID_BITS + TIME_BITS;
    localparam logic [COUNT_W-1:0] CNT_MAX = {COUNT_W{1'b1}};

    // Entry layout: {source, destination, time}.
    logic [ENT_W-1:0] mem [DEPTH];

    logic [AW-1:0]        r_head;
    logic [OW-1:0]        r_occ;
    logic [LIMIT_W-1:0]   r_limit;
    t_func                r_func;
    logic [ID_BITS-1:0]   r_src;
    logic [ID_BITS-1:0]   r_dst;
    logic [TIME_BITS-1:0] r_ts;
    logic [TIME_BITS-1:0] r_lo;
    logic [TIME_BITS-1:0] r_hi;
    logic [OW-1:0]        r_idx;
    logic                 r_pend;
    logic                 r_hit;
    logic [COUNT_W-1:0]   r_cnt;
    logic [ENT_W-1:0]     r_rd_data;

    logic [OW:0]          off;
    logic [OW:0]          sum;
    logic [OW:0]          sum_wrap;
    logic [AW-1:0]        slot;
    logic [AW-1:0]        head_inc;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 evict;
    logic [ID_BITS-1:0]   rd_src;
    logic [ID_BITS-1:0]   rd_dst;
    logic [TIME_BITS-1:0] rd_ts;
    logic                 dup_match;
    logic                 cnt_match;
    logic                 fwd_found;

    // Slot of the entry at a given offset from the oldest one.
    assign off      = i_cmd.write ? {1'b0, r_occ} : {1'b0, r_idx};
    assign sum      = (OW + 1)'(r_head) + off;
    assign sum_wrap = (sum >= (OW + 1)'(DEPTH)) ? sum - (OW + 1)'(DEPTH) : sum;
    assign slot     = sum_wrap[AW-1:0];
    assign head_inc = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + 1'b1;

    assign rd_en   = i_cmd.rd_head || (i_cmd.scan && (r_idx != r_occ));
    assign rd_addr = i_cmd.rd_head ? r_head : slot;

    // A limit of zero behaves as one; a full ring always evicts.
    assign evict = (r_occ != '0) &&
                   ((CW'(r_occ) >= CW'(r_limit)) || (r_occ == OW'(DEPTH)));

    assign rd_src = r_rd_data[ENT_W-1 -: ID_BITS];
    assign rd_dst = r_rd_data[TIME_BITS +: ID_BITS];
    assign rd_ts  = r_rd_data[TIME_BITS-1:0];

    assign dup_match = (rd_src == r_src) && (rd_dst == r_dst) && (rd_ts == r_ts);
    assign cnt_match = (rd_dst == r_dst) && (rd_ts >= r_lo) && (rd_ts <= r_hi);
    assign fwd_found = (r_func == FUNC_FWD) && (r_occ != '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            mem[slot] <= {r_src, r_dst, r_ts};
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= t_func'(i_func);
            r_src  <= i_source;
            r_dst  <= i_destination;
            r_ts   <= i_timestamp;
            r_lo   <= i_start_time;
            r_hi   <= i_end_time;
        end
        if (i_cmd.finish) begin
            o_accepted        <= (r_func == FUNC_ADD) && !r_hit;
            o_found           <= fwd_found;
            o_out_source      <= fwd_found ? rd_src : '0;
            o_out_destination <= fwd_found ? rd_dst : '0;
            o_out_timestamp   <= fwd_found ? rd_ts : '0;
            o_match_count     <= (r_func == FUNC_COUNT) ? r_cnt : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_occ   <= '0;
            r_limit <= LIMIT_RESET;
            r_idx   <= '0;
            r_pend  <= 1'b0;
            r_hit   <= 1'b0;
            r_cnt   <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.finish;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
                r_hit  <= 1'b0;
                r_cnt  <= '0;
            end else if (i_cmd.scan) begin
                if (r_idx != r_occ) begin
                    r_idx <= r_idx + 1'b1;
                end
                r_pend <= (r_idx != r_occ);
            end
            // The read issued in the previous cycle is compared here.
            if (r_pend) begin
                if (r_func == FUNC_ADD && dup_match) begin
                    r_hit <= 1'b1;
                end
                if (r_func == FUNC_COUNT && cnt_match && r_cnt != CNT_MAX) begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
            if (i_cmd.write) begin
                if (evict) begin
                    r_head <= head_inc;
                end else begin
                    r_occ <= r_occ + 1'b1;
                end
            end else if (i_cmd.finish && fwd_found) begin
                r_head <= head_inc;
                r_occ  <= r_occ - 1'b1;
            end
        end
    end

    assign o_status.func     = r_func;
    assign o_status.scan_end = (r_idx == r_occ) && !r_pend;
    assign o_status.hit      = r_hit;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OW'(DEPTH))
        else $error("occupancy exceeds ring depth");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && r_func == FUNC_COUNT) |-> (CW'(o_match_count) <= CW'(r_occ)))
        else $error("match count larger than occupancy");

    a_write_no_dup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.write |-> !r_hit && !r_pend)
        else $error("append issued for a duplicate or before the scan ended");

endmodule
`default_nettype wire

// ===== rtl/packet_buffer_dedup_fifo_unit.sv =====
// Top level of the bounded packet FIFO with duplicate filter.
`timescale 1ns / 1ps
`default_nettype none
// How to use this block:
// A command word is taken at a rising edge where start is high and busy is low.
// i_func selects add (0), forward oldest (1), count in a time window (2) or no-op (3).
// Exactly one result word follows per command: o_valid is high for a single cycle
// and the result fields are valid in that cycle only. The receiver cannot stall,
// so it must take every result as it appears.
// Add and count scan every stored entry through the single read port of the ring
// memory, one entry per cycle; an add that is appended then writes it in ST_WRITE.
// Forward reads the oldest entry in ST_RDHEAD and a no-op goes straight to ST_FINISH.
// Busy stays high until the strobe cycle, so one command is in flight at a time.
// The capacity register is written through i_cfg_valid / o_cfg_ready, which is
// always ready; write it only while the block is idle. A value of zero behaves
// as one, and values above DEPTH behave as DEPTH. Lowering it below the current
// fill evicts only one entry per later accepted add.
// Reset empties the buffer, sets the capacity to 64 and clears the strobe.
// Memory contents are not cleared; data from unoccupied slots never reaches a result.
module packet_buffer_dedup_fifo_unit #(
    parameter int DEPTH     = pbd_pkg::DEPTH_DEF,
    parameter int ID_BITS   = pbd_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = pbd_pkg::TIME_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [pbd_pkg::FUNC_W-1:0]    i_func,
    input  wire logic [ID_BITS-1:0]            i_source,
    input  wire logic [ID_BITS-1:0]            i_destination,
    input  wire logic [TIME_BITS-1:0]          i_timestamp,
    input  wire logic [TIME_BITS-1:0]          i_start_time,
    input  wire logic [TIME_BITS-1:0]          i_end_time,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [pbd_pkg::LIMIT_W-1:0]   i_cfg_data,
    output logic                               o_valid,
    output logic                               o_accepted,
    output logic                               o_found,
    output logic [ID_BITS-1:0]                 o_out_source,
    output logic [ID_BITS-1:0]                 o_out_destination,
    output logic [TIME_BITS-1:0]               o_out_timestamp,
    output logic [pbd_pkg::COUNT_W-1:0]        o_match_count
);
    import pbd_pkg::*;

    t_cmd    cmd;
    t_status status;

    // The capacity register has no side effects, so writes are always taken.
    assign o_cfg_ready = 1'b1;

    pbd_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    pbd_dpath #(
        .DEPTH     (DEPTH),
        .ID_BITS   (ID_BITS),
        .TIME_BITS (TIME_BITS)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_cfg_we          (i_cfg_valid && o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .i_func            (i_func),
        .i_source          (i_source),
        .i_destination     (i_destination),
        .i_timestamp       (i_timestamp),
        .i_start_time      (i_start_time),
        .i_end_time        (i_end_time),
        .o_valid           (o_valid),
        .o_accepted        (o_accepted),
        .o_found           (o_found),
        .o_out_source      (o_out_source),
        .o_out_destination (o_out_destination),
        .o_out_timestamp   (o_out_timestamp),
        .o_match_count     (o_match_count)
    );

endmodule
`default_nettype wire

// ===== tb/pbd_result_checker.sv =====
// Checker for the deduplicating packet FIFO: watches the command, capacity and result words.
`timescale 1ns / 1ps
module pbd_result_checker #(
    parameter int DEPTH     = pbd_pkg::DEPTH_DEF,
    parameter int ID_BITS   = pbd_pkg::ID_BITS_DEF,
    parameter int TIME_BITS = pbd_pkg::TIME_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic [pbd_pkg::FUNC_W-1:0]    func,
    input  logic [ID_BITS-1:0]            source,
    input  logic [ID_BITS-1:0]            destination,
    input  logic [TIME_BITS-1:0]          timestamp,
    input  logic [TIME_BITS-1:0]          start_time,
    input  logic [TIME_BITS-1:0]          end_time,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  logic [pbd_pkg::LIMIT_W-1:0]   cfg_data,
    input  logic                          res_valid,
    input  logic                          res_accepted,
    input  logic                          res_found,
    input  logic [ID_BITS-1:0]            res_source,
    input  logic [ID_BITS-1:0]            res_destination,
    input  logic [TIME_BITS-1:0]          res_timestamp,
    input  logic [pbd_pkg::COUNT_W-1:0]   res_match_count,
    output int                            fail_count,
    output int                            outstanding
);
    import pbd_pkg::*;

    localparam int PEND_DEPTH = 16;

    typedef struct packed {
        logic                 accepted;
        logic                 found;
        logic [ID_BITS-1:0]   src;
        logic [ID_BITS-1:0]   dst;
        logic [TIME_BITS-1:0] ts;
        logic [COUNT_W-1:0]   count;
    } t_result_word;

    // Shadow copy of the ring buffer and the capacity register.
    logic [ID_BITS-1:0]   ring_src [DEPTH];
    logic [ID_BITS-1:0]   ring_dst [DEPTH];
    logic [TIME_BITS-1:0] ring_ts  [DEPTH];
    int unsigned          head;
    int unsigned          fill;
    logic [LIMIT_W-1:0]   capacity;

    // Expected result words in command order.
    t_result_word expected_words [PEND_DEPTH];
    int unsigned  wr_ptr;
    int unsigned  rd_ptr;

    function automatic int unsigned ring_slot(int unsigned offset);
        return (head + offset) % DEPTH;
    endfunction

    // Applies one command to the shadow buffer and returns the result word it yields.
    function automatic t_result_word execute_command(
        t_func                f,
        logic [ID_BITS-1:0]   src,
        logic [ID_BITS-1:0]   dst,
        logic [TIME_BITS-1:0] ts,
        logic [TIME_BITS-1:0] lo,
        logic [TIME_BITS-1:0] hi
    );
        t_result_word w;
        int unsigned  cap;
        int unsigned  hits;
        int unsigned  s;
        bit           dup;
        w    = '0;
        hits = 0;
        dup  = 1'b0;
        case (f)
            FUNC_ADD: begin
                for (int unsigned i = 0; i < fill; i++) begin
                    s = ring_slot(i);
                    if (ring_src[s] == src && ring_dst[s] == dst && ring_ts[s] == ts)
                        dup = 1'b1;
                end
                if (!dup) begin
                    // Zero behaves as one and anything past the depth as the depth.
                    cap = (capacity == 0) ? 1 : ((capacity > DEPTH) ? DEPTH : capacity);
                    if (fill >= cap) begin
                        head = ring_slot(1);
                        fill--;
                    end
                    s = ring_slot(fill);
                    ring_src[s] = src;
                    ring_dst[s] = dst;
                    ring_ts[s]  = ts;
                    fill++;
                    w.accepted = 1'b1;
                end
            end
            FUNC_FWD: begin
                if (fill != 0) begin
                    w.found = 1'b1;
                    w.src   = ring_src[head];
                    w.dst   = ring_dst[head];
                    w.ts    = ring_ts[head];
                    head    = ring_slot(1);
                    fill--;
                end
            end
            FUNC_COUNT: begin
                for (int unsigned i = 0; i < fill; i++) begin
                    s = ring_slot(i);
                    if (ring_dst[s] == dst && ring_ts[s] >= lo && ring_ts[s] <= hi)
                        hits++;
                end
                w.count = (hits > 127) ? 7'd127 : hits[COUNT_W-1:0];
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t ns: %s is %0h, expected %0h", $realtime, what, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin : watch
        t_result_word want;
        if (!i_rst_n) begin
            head       = 0;
            fill       = 0;
            capacity   = LIMIT_RESET;
            wr_ptr     = 0;
            rd_ptr     = 0;
            fail_count = 0;
            outstanding <= 0;
        end else begin
            // The result is checked before a command accepted at the same edge is predicted.
            if (res_valid) begin
                if (wr_ptr == rd_ptr) begin
                    flag_mismatch("unexpected result word", 64'd1, 64'd0);
                end else begin
                    want = expected_words[rd_ptr % PEND_DEPTH];
                    rd_ptr++;
                    if (res_accepted !== want.accepted)
                        flag_mismatch("accepted", 64'(res_accepted), 64'(want.accepted));
                    if (res_found !== want.found)
                        flag_mismatch("found", 64'(res_found), 64'(want.found));
                    if (res_source !== want.src)
                        flag_mismatch("out_source", 64'(res_source), 64'(want.src));
                    if (res_destination !== want.dst)
                        flag_mismatch("out_destination", 64'(res_destination),
                                      64'(want.dst));
                    if (res_timestamp !== want.ts)
                        flag_mismatch("out_timestamp", 64'(res_timestamp), 64'(want.ts));
                    if (res_match_count !== want.count)
                        flag_mismatch("match_count", 64'(res_match_count), 64'(want.count));
                end
            end
            if (cfg_valid && cfg_ready)
                capacity = cfg_data;
            if (start && !busy) begin
                expected_words[wr_ptr % PEND_DEPTH] = execute_command(t_func'(func), source,
                                                                      destination, timestamp,
                                                                      start_time, end_time);
                wr_ptr++;
            end
            outstanding <= int'(wr_ptr - rd_ptr);
        end
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the testbench for the deduplicating packet FIFO: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import pbd_pkg::*;

    localparam int IDW = ID_BITS_DEF;
    localparam int TW  = TIME_BITS_DEF;

    // Number of random phases, each with its own capacity and operation mix.
    localparam int NPHASE          = 9;
    localparam int WORDS_PER_PHASE = 140;

    // Capacity per phase. Zero and anything above the depth are folded by the block,
    // and the drop from 64 to 3 leaves the buffer holding more than its new capacity.
    localparam logic [LIMIT_W-1:0] PHASE_LIMIT [NPHASE] =
        '{7'd64, 7'd127, 7'd1, 7'd0, 7'd65, 7'd64, 7'd3, 7'd17, 7'd2};
    // Percent of adds and of forwards per phase; counts take the rest up to 95,
    // and the last five percent are no-ops.
    localparam int PHASE_ADD [NPHASE] = '{55, 50, 40, 45, 50, 75, 45, 50, 40};
    localparam int PHASE_FWD [NPHASE] = '{15, 20, 25, 25, 15, 10, 20, 20, 25};

    logic                 i_clk;
    logic                 i_rst_n       = 1'b0;
    logic                 start         = 1'b0;
    logic                 busy;
    logic [FUNC_W-1:0]    i_func        = FUNC_NOP;
    logic [IDW-1:0]       i_source      = '0;
    logic [IDW-1:0]       i_destination = '0;
    logic [TW-1:0]        i_timestamp   = '0;
    logic [TW-1:0]        i_start_time  = '0;
    logic [TW-1:0]        i_end_time    = '0;
    logic                 i_cfg_valid   = 1'b0;
    logic                 o_cfg_ready;
    logic [LIMIT_W-1:0]   i_cfg_data    = LIMIT_RESET;
    logic                 o_valid;
    logic                 o_accepted;
    logic                 o_found;
    logic [IDW-1:0]       o_out_source;
    logic [IDW-1:0]       o_out_destination;
    logic [TW-1:0]        o_out_timestamp;
    logic [COUNT_W-1:0]   o_match_count;

    int fail_count;
    int outstanding;

    // Recently added triples. Replaying them produces duplicates while they are stored
    // and fresh adds once they have been evicted or forwarded.
    logic [IDW-1:0] recent_src [16] = '{default: '0};
    logic [IDW-1:0] recent_dst [16] = '{default: '0};
    logic [TW-1:0]  recent_ts  [16] = '{default: '0};
    int             recent_total = 0;

    int n_add = 0;
    int n_fwd = 0;
    int n_count = 0;
    int n_nop = 0;

    packet_buffer_dedup_fifo_unit DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_source          (i_source),
        .i_destination     (i_destination),
        .i_timestamp       (i_timestamp),
        .i_start_time      (i_start_time),
        .i_end_time        (i_end_time),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_accepted        (o_accepted),
        .o_found           (o_found),
        .o_out_source      (o_out_source),
        .o_out_destination (o_out_destination),
        .o_out_timestamp   (o_out_timestamp),
        .o_match_count     (o_match_count)
    );

    pbd_result_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .func            (i_func),
        .source          (i_source),
        .destination     (i_destination),
        .timestamp       (i_timestamp),
        .start_time      (i_start_time),
        .end_time        (i_end_time),
        .cfg_valid       (i_cfg_valid),
        .cfg_ready       (o_cfg_ready),
        .cfg_data        (i_cfg_data),
        .res_valid       (o_valid),
        .res_accepted    (o_accepted),
        .res_found       (o_found),
        .res_source      (o_out_source),
        .res_destination (o_out_destination),
        .res_timestamp   (o_out_timestamp),
        .res_match_count (o_match_count),
        .fail_count      (fail_count),
        .outstanding     (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Safety net: the slowest correct run is far shorter than this.
    initial begin
        #(5_000_000);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Presents one command word and returns at the edge where it is taken. Start is
    // left high, so a following call keeps it high without a second assignment in
    // the same step, and commands go in back to back.
    task automatic send(t_func f, logic [IDW-1:0] src, logic [IDW-1:0] dst,
                        logic [TW-1:0] ts, logic [TW-1:0] lo, logic [TW-1:0] hi);
        start         <= 1'b1;
        i_func        <= f;
        i_source      <= src;
        i_destination <= dst;
        i_timestamp   <= ts;
        i_start_time  <= lo;
        i_end_time    <= hi;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        case (f)
            FUNC_ADD:   n_add++;
            FUNC_FWD:   n_fwd++;
            FUNC_COUNT: n_count++;
            default:    n_nop++;
        endcase
    endtask

    // Drops start and lets the given number of cycles pass.
    task automatic pause(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Waits until the block is idle and every expected word has arrived, then writes
    // the capacity register through its own channel.
    task automatic set_capacity(logic [LIMIT_W-1:0] value);
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0 || busy) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Identifiers lean toward the extremes and a few repeated values, so that
    // random triples collide now and then; the rest is uniform over all bits.
    function automatic logic [IDW-1:0] pick_id();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 16'h0001;
            3:       return 16'h8000;
            4:       return 16'h00A5;
            default: return IDW'($urandom);
        endcase
    endfunction

    function automatic logic [TW-1:0] pick_time();
        case ($urandom_range(0, 9))
            0:          return '0;
            1:          return '1;
            2, 3, 4, 5: return $urandom_range(0, 200);
            default:    return $urandom;
        endcase
    endfunction

    // Builds and sends one random command. Adds mostly carry new packets and
    // sometimes replay a recent one; counts usually aim at a stored destination
    // with a window around a stored timestamp.
    task automatic send_random(int add_pct, int fwd_pct);
        int             roll;
        int             pick;
        int             span;
        logic [IDW-1:0] src;
        logic [IDW-1:0] dst;
        logic [TW-1:0]  ts;
        logic [TW-1:0]  lo;
        logic [TW-1:0]  hi;
        roll = $urandom_range(0, 99);
        span = (recent_total < 16) ? recent_total : 16;
        pick = (span > 0) ? $urandom_range(0, span - 1) : 0;
        src  = IDW'($urandom);
        dst  = IDW'($urandom);
        ts   = $urandom;
        lo   = $urandom;
        hi   = $urandom;
        if (roll < add_pct) begin
            if (span > 0 && $urandom_range(0, 3) == 0) begin
                src = recent_src[pick];
                dst = recent_dst[pick];
                ts  = recent_ts[pick];
            end else begin
                src = pick_id();
                dst = pick_id();
                ts  = pick_time();
                recent_src[recent_total % 16] = src;
                recent_dst[recent_total % 16] = dst;
                recent_ts[recent_total % 16]  = ts;
                recent_total++;
            end
            send(FUNC_ADD, src, dst, ts, lo, hi);
        end else if (roll < add_pct + fwd_pct) begin
            send(FUNC_FWD, src, dst, ts, lo, hi);
        end else if (roll < 95) begin
            dst = (span > 0 && $urandom_range(0, 3) != 0) ? recent_dst[pick] : pick_id();
            case ($urandom_range(0, 5))
                0: begin
                    lo = '0;
                    hi = '1;
                end
                1, 2: begin
                    // A window around a stored time; wrapping below zero inverts it.
                    lo = recent_ts[pick] - TW'($urandom_range(0, 3));
                    hi = recent_ts[pick] + TW'($urandom_range(0, 50));
                end
                3: begin
                    lo = recent_ts[pick];
                    hi = recent_ts[pick];
                end
                4: begin
                    // Inverted window, which must match nothing.
                    lo = recent_ts[pick] + 1;
                    hi = recent_ts[pick];
                end
                default: ;
            endcase
            send(FUNC_COUNT, src, dst, ts, lo, hi);
        end else begin
            send(FUNC_NOP, src, dst, ts, lo, hi);
        end
    endtask

    initial begin : stimulus
        bit idling;
        // Reset is held low at the start and never again.
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part at the reset capacity. First the empty buffer: a forward
        // reports nothing found, a count finds nothing, and a no-op with every
        // field at its maximum returns all zeros.
        send(FUNC_FWD, '0, '0, '0, '0, '0);
        send(FUNC_COUNT, '0, '0, '0, '0, '1);
        send(FUNC_NOP, '1, '1, '1, '1, '1);
        // Extreme triples, an exact duplicate and one differing only in source.
        send(FUNC_ADD, '0, '0, '0, '0, '0);
        send(FUNC_ADD, '0, '0, '0, '1, '1);
        send(FUNC_ADD, '1, '1, '1, '0, '0);
        pause(3);
        send(FUNC_ADD, '1, '0, '0, '0, '0);
        // Full window, single point at the top, and an inverted window.
        send(FUNC_COUNT, '0, '0, '0, '0, '1);
        send(FUNC_COUNT, '0, '1, '0, '1, '1);
        send(FUNC_COUNT, '0, '0, '0, 32'd5, 32'd4);
        send(FUNC_FWD, '0, '0, '0, '0, '0);
        send(FUNC_NOP, '0, '0, '0, '0, '0);
        send(FUNC_FWD, '1, '1, '1, '1, '1);
        pause(1);
        send(FUNC_FWD, '0, '0, '0, '0, '0);
        // Now empty again: one forward too many.
        send(FUNC_FWD, '0, '0, '0, '0, '0);

        // A capacity of zero acts as one: the second add evicts the first silently,
        // and the evicted packet can then be added again without being a duplicate.
        set_capacity(7'd0);
        send(FUNC_ADD, 16'h1234, 16'h00A5, 32'd100, '0, '0);
        send(FUNC_ADD, 16'h4321, 16'h00A5, 32'd101, '0, '0);
        send(FUNC_COUNT, '0, 16'h00A5, '0, 32'd100, 32'd100);
        send(FUNC_ADD, 16'h1234, 16'h00A5, 32'd100, '0, '0);
        send(FUNC_FWD, '0, '0, '0, '0, '0);
        send(FUNC_FWD, '0, '0, '0, '0, '0);

        // Random phases. Idle pauses are switched on and off in stretches, and never
        // come in the last phase, so the block also sees commands arriving as fast as
        // it can take them.
        idling = 1'b1;
        for (int p = 0; p < NPHASE; p++) begin
            set_capacity(PHASE_LIMIT[p]);
            for (int k = 0; k < WORDS_PER_PHASE; k++) begin
                if (k % 35 == 0)
                    idling = (p != NPHASE - 1) && ($urandom_range(0, 2) != 0);
                send_random(PHASE_ADD[p], PHASE_FWD[p]);
                if (idling && $urandom_range(0, 2) == 0)
                    pause($urandom_range(1, 15));
            end
        end

        // Drain: every expected word must arrive, then a quiet tail catches any
        // stray strobe. The tail exceeds the longest scan of a full buffer.
        start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0 || busy) @(posedge i_clk);
        repeat (DEPTH_DEF + 16) @(posedge i_clk);

        $display("Sent %0d adds, %0d forwards, %0d counts and %0d no-ops", n_add, n_fwd,
                 n_count, n_nop);
        $display("across %0d capacity settings, including zero, one, 127 and a cut below fill.",
                 NPHASE + 1);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/pbd_pkg.sv
rtl/pbd_ctrl.sv
rtl/pbd_dpath.sv
rtl/packet_buffer_dedup_fifo_unit.sv
tb/pbd_result_checker.sv
tb/testbench.sv
